// ----- design/bstq_pkg.sv -----
package bstq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 31;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_SKIP   = 2'd1,
        CMD_MARK   = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_EXPIRE_MS = 1'd0,
        REG_GRID_MS   = 1'd1
    } cfg_reg_t;

    typedef struct packed {
        cmd_t        command;
        logic [23:0] byte_count;
        logic [47:0] time_ms;
    } in_t;

    typedef struct packed {
        logic        timed_out;
        logic [3:0]  queued_marks;
        logic [31:0] buffered_bytes;
    } out_t;

    function automatic idx_t ring_next(idx_t i);
        idx_t r;
        begin
            if (i == idx_t'(QUEUE_DEPTH - 1))
                r = '0;
            else
                r = i + idx_t'(1);
            return r;
        end
    endfunction

    function automatic idx_t ring_prev(idx_t i);
        idx_t r;
        begin
            if (i == '0)
                r = idx_t'(QUEUE_DEPTH - 1);
            else
                r = i - idx_t'(1);
            return r;
        end
    endfunction

    // marks held in the ring, (tail - head) mod depth, reported in 4 bits
    function automatic logic [3:0] mark_count(idx_t head, idx_t tail);
        int d;
        begin
            d = int'(tail) - int'(head);
            if (d < 0)
                d = d + QUEUE_DEPTH;
            return 4'(d);
        end
    endfunction

endpackage

// ----- design/byte_stream_timestamp_queue_top.sv -----
// Append adds to the byte counters; skip drains all, or subtracts and walks the head
// over marks whose data is consumed; mark and query subtract a stored time (newest mark,
// head mark), at most 15 marks held; one shared 50-bit subtractor does all magnitude compares.
// One transaction in flight, in_ready high only in idle; the next one is taken
// after out_valid rises, and a finished one waits in DONE while the last output is unread.
// Reset (rst_n, async, active low): counters, ring, output, expire_ms 0, grid 100; no mem clear.
module byte_stream_timestamp_queue_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bstq_pkg::in_t                       in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output bstq_pkg::out_t                      out_data,
    input  logic                                cfg_we,
    input  logic [bstq_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [bstq_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_APPEND,
        S_SKIP_CHK,
        S_SKIP_RD,
        S_SKIP_CMP,
        S_MARK_CHK,
        S_MARK_SUB,
        S_MARK_CMP,
        S_QRY_CHK,
        S_QRY_SUB,
        S_QRY_CMP,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;

    // Latched transaction
    bstq_pkg::cmd_t        cmd_reg;
    logic [23:0]           cnt_reg;
    logic [47:0]           time_reg;

    // Configuration
    logic [30:0]           expire_reg;
    logic [15:0]           grid_reg;

    // Ring and counters
    bstq_pkg::idx_t        head_reg, head_next;
    bstq_pkg::idx_t        tail_reg, tail_next;
    bstq_pkg::idx_t        nh_reg, nh_next;
    logic [31:0]           cached_reg, cached_next;
    logic [31:0]           skipped_reg, skipped_next;
    logic [31:0]           buffered_reg, buffered_next;

    // Working registers
    logic [48:0]           diff_reg, diff_next;
    logic                  to_reg, to_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    bstq_pkg::out_t        out_data_reg, out_data_next;

    // Mark memories (no reset: entries are only read after being written)
    logic [31:0]           mark_offset [bstq_pkg::QUEUE_DEPTH];
    logic [47:0]           mark_time   [bstq_pkg::QUEUE_DEPTH];
    bstq_pkg::idx_t        rd_addr;
    logic [31:0]           off_rd_reg;
    logic [47:0]           time_rd_reg;
    bstq_pkg::idx_t        wr_addr;
    logic                  we_off;
    logic                  we_time;

    // Shared subtractor: sign of (a - b) drives every magnitude compare
    logic [49:0]           alu_a, alu_b, alu_res;
    logic                  alu_neg;

    assign alu_res = alu_a - alu_b;
    assign alu_neg = alu_res[49];

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Read address follows the state so the registered read lines up
    always_comb
    begin
        unique case (state_reg)
            S_SKIP_RD,
            S_SKIP_CMP:  rd_addr = nh_reg;
            S_MARK_CHK,
            S_MARK_SUB,
            S_MARK_CMP:  rd_addr = bstq_pkg::ring_prev(tail_reg);
            default:     rd_addr = head_reg;
        endcase
    end

    // Operand select for the shared subtractor
    always_comb
    begin
        unique case (state_reg)
            S_SKIP_CHK:
            begin
                alu_a = {26'd0, cnt_reg};
                alu_b = {18'd0, buffered_reg};
            end
            S_SKIP_CMP:
            begin
                alu_a = {18'd0, skipped_reg};
                alu_b = {18'd0, off_rd_reg};
            end
            S_MARK_SUB,
            S_QRY_SUB:
            begin
                alu_a = {2'd0, time_reg};
                alu_b = {2'd0, time_rd_reg};
            end
            S_MARK_CMP:
            begin
                alu_a = {diff_reg[48], diff_reg};
                alu_b = {34'd0, grid_reg};
            end
            S_QRY_CMP:
            begin
                alu_a = {19'd0, expire_reg};
                alu_b = {diff_reg[48], diff_reg};
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    // Sequencer next-state logic
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        nh_next        = nh_reg;
        cached_next    = cached_reg;
        skipped_next   = skipped_reg;
        buffered_next  = buffered_reg;
        diff_next      = diff_reg;
        to_next        = to_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr_addr        = tail_reg;
        we_off         = 1'b0;
        we_time        = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    to_next = 1'b0;
                    unique case (in_data.command)
                        bstq_pkg::CMD_APPEND: state_next = S_APPEND;
                        bstq_pkg::CMD_SKIP:   state_next = S_SKIP_CHK;
                        bstq_pkg::CMD_MARK:   state_next = S_MARK_CHK;
                        bstq_pkg::CMD_QUERY:  state_next = S_QRY_CHK;
                    endcase
                end
            end

            S_APPEND:
            begin
                cached_next   = cached_reg + {8'd0, cnt_reg};
                buffered_next = buffered_reg + {8'd0, cnt_reg};
                state_next    = S_DONE;
            end

            S_SKIP_CHK:
            begin
                if (!alu_neg)
                begin
                    // full drain: count >= buffered
                    head_next     = '0;
                    tail_next     = '0;
                    cached_next   = '0;
                    skipped_next  = '0;
                    buffered_next = '0;
                    state_next    = S_DONE;
                end
                else
                begin
                    buffered_next = buffered_reg - {8'd0, cnt_reg};
                    if (head_reg == tail_reg)
                        state_next = S_DONE;
                    else
                    begin
                        skipped_next = skipped_reg + {8'd0, cnt_reg};
                        nh_next      = bstq_pkg::ring_next(head_reg);
                        state_next   = S_SKIP_RD;
                    end
                end
            end

            S_SKIP_RD:
            begin
                if (nh_reg == tail_reg)
                    state_next = S_DONE;
                else
                    state_next = S_SKIP_CMP;
            end

            S_SKIP_CMP:
            begin
                // offset <= skipped: data of the head mark is consumed
                if (!alu_neg)
                begin
                    head_next  = nh_reg;
                    nh_next    = bstq_pkg::ring_next(nh_reg);
                    state_next = S_SKIP_RD;
                end
                else
                    state_next = S_DONE;
            end

            S_MARK_CHK:
            begin
                if (head_reg == tail_reg)
                begin
                    we_off     = 1'b1;
                    we_time    = 1'b1;
                    tail_next  = bstq_pkg::ring_next(tail_reg);
                    state_next = S_DONE;
                end
                else if (head_reg == bstq_pkg::ring_next(tail_reg))
                    state_next = S_DONE;
                else
                    state_next = S_MARK_SUB;
            end

            S_MARK_SUB:
            begin
                diff_next  = alu_res[48:0];
                state_next = S_MARK_CMP;
            end

            S_MARK_CMP:
            begin
                if (!alu_neg)
                begin
                    if (off_rd_reg == cached_reg)
                    begin
                        // no bytes since last mark: refresh its time
                        wr_addr = bstq_pkg::ring_prev(tail_reg);
                        we_time = 1'b1;
                    end
                    else
                    begin
                        we_off    = 1'b1;
                        we_time   = 1'b1;
                        tail_next = bstq_pkg::ring_next(tail_reg);
                    end
                end
                state_next = S_DONE;
            end

            S_QRY_CHK:
            begin
                if (head_reg == tail_reg || skipped_reg == cached_reg)
                    state_next = S_DONE;
                else
                    state_next = S_QRY_SUB;
            end

            S_QRY_SUB:
            begin
                diff_next  = alu_res[48:0];
                state_next = S_QRY_CMP;
            end

            S_QRY_CMP:
            begin
                to_next    = alu_neg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.timed_out      = to_reg;
                    out_data_next.queued_marks   = bstq_pkg::mark_count(head_reg, tail_reg);
                    out_data_next.buffered_bytes = buffered_reg;
                    state_next                   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            nh_reg        <= '0;
            cached_reg    <= '0;
            skipped_reg   <= '0;
            buffered_reg  <= '0;
            to_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            nh_reg        <= nh_next;
            cached_reg    <= cached_next;
            skipped_reg   <= skipped_next;
            buffered_reg  <= buffered_next;
            to_reg        <= to_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expire_reg <= 31'd0;
            grid_reg   <= 16'd100;
        end
        else if (cfg_we)
        begin
            unique case (bstq_pkg::cfg_reg_t'(cfg_addr))
                bstq_pkg::REG_EXPIRE_MS: expire_reg <= cfg_wdata;
                bstq_pkg::REG_GRID_MS:   grid_reg   <= cfg_wdata[15:0];
            endcase
        end
    end

    // Transaction latch and working payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg  <= in_data.command;
            cnt_reg  <= in_data.byte_count;
            time_reg <= in_data.time_ms;
        end
        diff_reg <= diff_next;
    end

    // Mark memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we_off)
            mark_offset[wr_addr] <= cached_reg;
        if (we_time)
            mark_time[wr_addr] <= time_reg;
        off_rd_reg  <= mark_offset[rd_addr];
        time_rd_reg <= mark_time[rd_addr];
    end

    // Assertions
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a transaction is in flight");

    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SKIP_CHK && !alu_neg) |=>
            (head_reg == '0 && tail_reg == '0 && buffered_reg == '0))
        else $error("full drain did not clear ring and counters");

    a_head_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SKIP_CMP) |=>
            (head_reg == $past(head_reg) || head_reg == bstq_pkg::ring_next($past(head_reg))))
        else $error("head moved by more than one entry in a walk step");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(head_reg) < bstq_pkg::QUEUE_DEPTH && int'(tail_reg) < bstq_pkg::QUEUE_DEPTH))
        else $error("ring index out of range");

    a_walk_only_on_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SKIP_RD || state_reg == S_SKIP_CMP) |-> (cmd_reg == bstq_pkg::CMD_SKIP))
        else $error("head walk entered for a non-skip command");

endmodule
